/* src/ots_pkg.sv */
// Package with the shared types, constants and decode functions of the operator token scanner.
package ots_pkg;

    // Counter widths.
    localparam int LINE_BITS   = 16;
    localparam int OFFSET_BITS = 24;

    // Depth of the bundle queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    // One input byte causes at most this many tokens.
    localparam int MAX_RESULTS = 3;
    localparam int SLOT_BITS   = 2;

    localparam logic [LINE_BITS-1:0]   LINE_MAX   = '1;
    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

    // Token kinds.
    localparam logic [4:0] KIND_LPAREN     = 5'd0;
    localparam logic [4:0] KIND_RPAREN     = 5'd1;
    localparam logic [4:0] KIND_LBRACE     = 5'd2;
    localparam logic [4:0] KIND_RBRACE     = 5'd3;
    localparam logic [4:0] KIND_COMMA      = 5'd4;
    localparam logic [4:0] KIND_DOT        = 5'd5;
    localparam logic [4:0] KIND_MINUS      = 5'd6;
    localparam logic [4:0] KIND_PLUS       = 5'd7;
    localparam logic [4:0] KIND_SEMICOLON  = 5'd8;
    localparam logic [4:0] KIND_STAR       = 5'd9;
    localparam logic [4:0] KIND_BANG_EQ    = 5'd10;
    localparam logic [4:0] KIND_BANG       = 5'd11;
    localparam logic [4:0] KIND_EQ_EQ      = 5'd12;
    localparam logic [4:0] KIND_EQ         = 5'd13;
    localparam logic [4:0] KIND_GREATER_EQ = 5'd14;
    localparam logic [4:0] KIND_GREATER    = 5'd15;
    localparam logic [4:0] KIND_LESS_EQ    = 5'd16;
    localparam logic [4:0] KIND_LESS       = 5'd17;
    localparam logic [4:0] KIND_SLASH      = 5'd18;
    localparam logic [4:0] KIND_EOF        = 5'd19;
    localparam logic [4:0] KIND_ERROR      = 5'd20;

    // Source characters of interest.
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_SEMICOLON = 8'h3B;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_BANG      = 8'h21;
    localparam logic [7:0] CH_EQUAL     = 8'h3D;
    localparam logic [7:0] CH_GREATER   = 8'h3E;
    localparam logic [7:0] CH_LESS      = 8'h3C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;

    // Operator held in the lookahead.
    typedef enum logic [2:0] {
        OP_NONE    = 3'd0,
        OP_BANG    = 3'd1,
        OP_EQUAL   = 3'd2,
        OP_GREATER = 3'd3,
        OP_LESS    = 3'd4,
        OP_SLASH   = 3'd5
    } op_t;

    // One token as it leaves the block.
    typedef struct packed {
        logic [4:0]             kind;
        logic [1:0]             length;
        logic [OFFSET_BITS-1:0] start;
        logic [LINE_BITS-1:0]   line;
        logic [7:0]             bad;
    } result_t;

    // All tokens caused by one accepted byte, packed from slot zero up.
    typedef struct packed {
        result_t [MAX_RESULTS-1:0] res;
        logic [SLOT_BITS-1:0]      count;
    } bundle_t;

    // Queue status seen by the front and back parts.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Result of the single-character punctuator lookup.
    typedef struct packed {
        logic       hit;
        logic [4:0] kind;
    } punct_t;

    // Kind of a lookahead operator, alone or followed by an equals sign.
    function automatic logic [4:0] op_kind(input op_t op, input logic with_eq);
        logic [4:0] kind;
        case (op)
            OP_BANG:    kind = with_eq ? KIND_BANG_EQ : KIND_BANG;
            OP_EQUAL:   kind = with_eq ? KIND_EQ_EQ : KIND_EQ;
            OP_GREATER: kind = with_eq ? KIND_GREATER_EQ : KIND_GREATER;
            OP_LESS:    kind = with_eq ? KIND_LESS_EQ : KIND_LESS;
            default:    kind = KIND_SLASH;
        endcase
        return kind;
    endfunction

    // Operator that a byte opens, or none.
    function automatic op_t op_of(input logic [7:0] c);
        op_t op;
        case (c)
            CH_BANG:    op = OP_BANG;
            CH_EQUAL:   op = OP_EQUAL;
            CH_GREATER: op = OP_GREATER;
            CH_LESS:    op = OP_LESS;
            CH_SLASH:   op = OP_SLASH;
            default:    op = OP_NONE;
        endcase
        return op;
    endfunction

    // Single-character punctuator lookup.
    function automatic punct_t punct_of(input logic [7:0] c);
        punct_t p;
        p.hit = 1'b1;
        case (c)
            CH_LPAREN:    p.kind = KIND_LPAREN;
            CH_RPAREN:    p.kind = KIND_RPAREN;
            CH_LBRACE:    p.kind = KIND_LBRACE;
            CH_RBRACE:    p.kind = KIND_RBRACE;
            CH_COMMA:     p.kind = KIND_COMMA;
            CH_DOT:       p.kind = KIND_DOT;
            CH_MINUS:     p.kind = KIND_MINUS;
            CH_PLUS:      p.kind = KIND_PLUS;
            CH_SEMICOLON: p.kind = KIND_SEMICOLON;
            CH_STAR:      p.kind = KIND_STAR;
            default:
            begin
                p.hit  = 1'b0;
                p.kind = KIND_ERROR;
            end
        endcase
        return p;
    endfunction

endpackage

/* src/ots_ifs.sv */
// Handshake interfaces for the source byte channel and the token channel.
interface ots_byte_if;
    logic       valid;
    logic       ready;
    logic       has_char;
    logic [7:0] char_code;
    logic       is_final;

    modport source (output valid, output has_char, output char_code, output is_final,
                    input ready);
    modport sink (input valid, input has_char, input char_code, input is_final,
                  output ready);
endinterface

interface ots_token_if;
    logic                            valid;
    logic                            ready;
    logic [4:0]                      token_kind;
    logic [1:0]                      lexeme_length;
    logic [ots_pkg::OFFSET_BITS-1:0] start_offset;
    logic [ots_pkg::LINE_BITS-1:0]   line_number;
    logic [7:0]                      bad_char;
    logic                            run_last;

    modport source (output valid, output token_kind, output lexeme_length,
                    output start_offset, output line_number, output bad_char,
                    output run_last, input ready);
    modport sink (input valid, input token_kind, input lexeme_length,
                  input start_offset, input line_number, input bad_char,
                  input run_last, output ready);
endinterface

/* src/ots_front.sv */
// Front part: accepts source bytes, runs the scanner state and forms the token bundle of each byte.
module ots_front (
    input  logic                clk,
    input  logic                rst_n,
    ots_byte_if.sink            bytes,
    input  ots_pkg::q_status_t  q_status,
    output logic                push,
    output ots_pkg::bundle_t    push_data
);

    ots_pkg::op_t                    pending_op_reg, pending_op_next;
    logic [ots_pkg::OFFSET_BITS-1:0] pending_off_reg, pending_off_next;
    logic                            in_comment_reg, in_comment_next;
    logic [ots_pkg::LINE_BITS-1:0]   line_reg, line_next;
    logic [ots_pkg::OFFSET_BITS-1:0] offset_reg, offset_next;

    logic                  accept;
    logic                  has;
    logic [7:0]            c;
    logic                  fin;
    logic                  is_eq, is_slash, is_nl, is_blank;
    logic                  pend_none;
    logic                  combine, comment_start, fresh;
    ots_pkg::punct_t       pun;
    ots_pkg::op_t          fresh_op;
    logic                  unknown;
    logic                  a_valid, b_valid, c_valid, d_valid, m_valid;
    ots_pkg::result_t      res_a, res_b, res_c, res_d, res_m;
    ots_pkg::op_t          pend_after;
    logic [ots_pkg::OFFSET_BITS-1:0] pend_off_after;
    logic                  comm_after;
    logic [ots_pkg::LINE_BITS-1:0]   line_after;
    logic [ots_pkg::OFFSET_BITS-1:0] offset_after;

    // Take a byte whenever the queue has room for its bundle.
    assign bytes.ready = !q_status.full;
    assign accept      = bytes.valid && bytes.ready;

    assign has = bytes.has_char;
    assign c   = bytes.char_code;
    assign fin = bytes.is_final;

    // Byte classification.
    always_comb
    begin
        is_eq     = (c == ots_pkg::CH_EQUAL);
        is_slash  = (c == ots_pkg::CH_SLASH);
        is_nl     = (c == ots_pkg::CH_NEWLINE);
        is_blank  = (c == ots_pkg::CH_SPACE) || (c == ots_pkg::CH_TAB) ||
                    (c == ots_pkg::CH_CR);
        pun       = ots_pkg::punct_of(c);
        fresh_op  = ots_pkg::op_of(c);
        unknown   = !pun.hit && (fresh_op == ots_pkg::OP_NONE) && !is_blank && !is_nl;
        pend_none = (pending_op_reg == ots_pkg::OP_NONE);
    end

    // Lookahead resolution and the fresh scan of the byte.
    always_comb
    begin
        combine       = !pend_none && is_eq && (pending_op_reg != ots_pkg::OP_SLASH);
        comment_start = (pending_op_reg == ots_pkg::OP_SLASH) && is_slash;
        fresh         = has && !in_comment_reg && !combine && !comment_start;

        a_valid      = has && !in_comment_reg && !pend_none && !comment_start;
        res_a.kind   = ots_pkg::op_kind(pending_op_reg, combine);
        res_a.length = combine ? 2'd2 : 2'd1;
        res_a.start  = pending_off_reg;
        res_a.line   = line_reg;
        res_a.bad    = 8'd0;

        b_valid      = fresh && (pun.hit || unknown);
        res_b.kind   = pun.hit ? pun.kind : ots_pkg::KIND_ERROR;
        res_b.length = 2'd1;
        res_b.start  = offset_reg;
        res_b.line   = line_reg;
        res_b.bad    = pun.hit ? 8'd0 : c;
    end

    // State after the byte has been scanned.
    always_comb
    begin
        if (has && !in_comment_reg)
        begin
            pend_after = fresh ? fresh_op : ots_pkg::OP_NONE;
        end
        else
        begin
            pend_after = pending_op_reg;
        end
        pend_off_after = (fresh && (fresh_op != ots_pkg::OP_NONE)) ? offset_reg
                                                                   : pending_off_reg;
        if (!has)
        begin
            comm_after = in_comment_reg;
        end
        else if (in_comment_reg)
        begin
            comm_after = !is_nl;
        end
        else
        begin
            comm_after = comment_start;
        end
        line_after   = (has && is_nl && (line_reg != ots_pkg::LINE_MAX)) ?
                       line_reg + ots_pkg::LINE_BITS'(1) : line_reg;
        offset_after = (has && (offset_reg != ots_pkg::OFFSET_MAX)) ?
                       offset_reg + ots_pkg::OFFSET_BITS'(1) : offset_reg;
    end

    // Flush of the lookahead and the end-of-file token on a final item.
    always_comb
    begin
        c_valid      = fin && (pend_after != ots_pkg::OP_NONE);
        res_c.kind   = ots_pkg::op_kind(pend_after, 1'b0);
        res_c.length = 2'd1;
        res_c.start  = pend_off_after;
        res_c.line   = line_after;
        res_c.bad    = 8'd0;

        d_valid      = fin;
        res_d.kind   = ots_pkg::KIND_EOF;
        res_d.length = 2'd0;
        res_d.start  = offset_after;
        res_d.line   = line_after;
        res_d.bad    = 8'd0;

        // A fresh token and a flushed operator never occur together.
        m_valid = b_valid || c_valid;
        res_m   = b_valid ? res_b : res_c;
    end

    // Pack the valid tokens into the low slots of the bundle.
    always_comb
    begin
        push_data.count = ots_pkg::SLOT_BITS'(a_valid) + ots_pkg::SLOT_BITS'(m_valid) +
                          ots_pkg::SLOT_BITS'(d_valid);
        push_data.res[0] = a_valid ? res_a : (m_valid ? res_m : res_d);
        push_data.res[1] = (a_valid && m_valid) ? res_m : res_d;
        push_data.res[2] = res_d;
        push = accept && (push_data.count != '0);
    end

    // Next scanner state; a final item returns everything to the reset values.
    always_comb
    begin
        pending_op_next  = pending_op_reg;
        pending_off_next = pending_off_reg;
        in_comment_next  = in_comment_reg;
        line_next        = line_reg;
        offset_next      = offset_reg;
        if (accept)
        begin
            if (fin)
            begin
                pending_op_next  = ots_pkg::OP_NONE;
                pending_off_next = '0;
                in_comment_next  = 1'b0;
                line_next        = ots_pkg::LINE_BITS'(1);
                offset_next      = '0;
            end
            else
            begin
                pending_op_next  = pend_after;
                pending_off_next = pend_off_after;
                in_comment_next  = comm_after;
                line_next        = line_after;
                offset_next      = offset_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_op_reg  <= ots_pkg::OP_NONE;
            pending_off_reg <= '0;
            in_comment_reg  <= 1'b0;
            line_reg        <= ots_pkg::LINE_BITS'(1);
            offset_reg      <= '0;
        end
        else
        begin
            pending_op_reg  <= pending_op_next;
            pending_off_reg <= pending_off_next;
            in_comment_reg  <= in_comment_next;
            line_reg        <= line_next;
            offset_reg      <= offset_next;
        end
    end

endmodule

/* src/ots_queue.sv */
// Short register queue of token bundles between the front and back parts.
module ots_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ots_pkg::bundle_t    push_data,
    input  logic                pop,
    output ots_pkg::q_status_t  status,
    output ots_pkg::bundle_t    head
);

    ots_pkg::bundle_t                 mem_reg [ots_pkg::QUEUE_DEPTH];
    logic [ots_pkg::PTR_BITS-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [ots_pkg::PTR_BITS-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [ots_pkg::CNT_BITS-1:0]     count_reg, count_next;

    localparam logic [ots_pkg::PTR_BITS-1:0] LAST_PTR =
        ots_pkg::PTR_BITS'(ots_pkg::QUEUE_DEPTH - 1);
    localparam logic [ots_pkg::CNT_BITS-1:0] FULL_COUNT =
        ots_pkg::CNT_BITS'(ots_pkg::QUEUE_DEPTH);

    assign status.full  = (count_reg == FULL_COUNT);
    assign status.empty = (count_reg == '0);
    assign head         = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + ots_pkg::PTR_BITS'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + ots_pkg::PTR_BITS'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + ots_pkg::CNT_BITS'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - ots_pkg::CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Bundle storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* src/ots_back.sv */
// Back part: takes bundles from the queue and hands their tokens out one transfer at a time.
module ots_back (
    input  logic                clk,
    input  logic                rst_n,
    input  ots_pkg::q_status_t  q_status,
    input  ots_pkg::bundle_t    head,
    output logic                pop,
    ots_token_if.source         tokens
);

    logic                           out_valid_reg, out_valid_next;
    ots_pkg::result_t               out_res_reg, out_res_next;
    logic                           out_last_reg, out_last_next;
    logic [ots_pkg::SLOT_BITS-1:0]  slot_reg, slot_next;

    logic load;
    logic last_slot;

    // Load the output register when it is empty or its token is being transferred.
    assign load      = !q_status.empty && (!out_valid_reg || tokens.ready);
    assign last_slot = (slot_reg == head.count - ots_pkg::SLOT_BITS'(1));
    assign pop       = load && last_slot;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        out_last_next  = out_last_reg;
        slot_next      = slot_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_res_next   = head.res[slot_reg];
            out_last_next  = last_slot;
            slot_next      = last_slot ? '0 : slot_reg + ots_pkg::SLOT_BITS'(1);
        end
        else if (tokens.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            slot_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            slot_reg      <= slot_next;
        end
    end

    // Token payload.
    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        out_last_reg <= out_last_next;
    end

    assign tokens.valid         = out_valid_reg;
    assign tokens.token_kind    = out_res_reg.kind;
    assign tokens.lexeme_length = out_res_reg.length;
    assign tokens.start_offset  = out_res_reg.start;
    assign tokens.line_number   = out_res_reg.line;
    assign tokens.bad_char      = out_res_reg.bad;
    assign tokens.run_last      = out_last_reg;

endmodule

/* src/operator_token_scanner.sv */
// Top level of the operator token scanner: front part, bundle queue and back part.
// The scanner takes one source byte per cycle while the queue is not full and emits
// the punctuator, operator, error and end-of-file tokens it causes, each with start
// offset, length and line. A byte that yields one token or none is taken every cycle
// while the token sink is ready; a byte that yields several tokens (at most three,
// on a final item) holds the single-token output stage until all are sent, and a
// two-bundle queue between the front and the output stage keeps taking bytes until
// it fills. A token is offered once its bundle has been written into the queue and
// then loaded into the output register; run_last marks the last token of each byte.
// A final item flushes the lookahead, emits end of file and restarts the scanner.
module operator_token_scanner (
    input  logic         clk,
    input  logic         rst_n,
    ots_byte_if.sink     bytes,
    ots_token_if.source  tokens
);

    ots_pkg::q_status_t q_status;
    ots_pkg::bundle_t   push_data;
    ots_pkg::bundle_t   head;
    logic               push;
    logic               pop;

    ots_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .bytes     (bytes),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    ots_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .status    (q_status),
        .head      (head)
    );

    ots_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .head     (head),
        .pop      (pop),
        .tokens   (tokens)
    );

endmodule

/* src/ots_checker.sv */
// Port-level checks on the token channel of the scanner, bound to the top level.
module ots_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       valid,
    input logic       ready,
    input logic [4:0] token_kind,
    input logic [1:0] lexeme_length,
    input logic [7:0] bad_char,
    input logic       run_last
);

    // A stalled token stays offered.
    a_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid)
        else $error("token withdrawn while stalled");

    // A stalled token keeps its kind and its end-of-run mark.
    a_token_held: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> $stable(token_kind) && $stable(run_last))
        else $error("token changed while stalled");

    // End of file has no length and always closes the run of its item.
    a_eof_shape: assert property (@(posedge clk) disable iff (!rst_n)
        valid && (token_kind == ots_pkg::KIND_EOF) |-> (lexeme_length == 2'd0) && run_last)
        else $error("malformed end-of-file token");

    // Only an error token carries a bad byte.
    a_bad_only_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        valid && (token_kind != ots_pkg::KIND_ERROR) |-> (bad_char == 8'd0))
        else $error("bad byte reported on a good token");

    // The token offered after an end-of-file transfer is end of file again or has a length.
    a_eof_then_new: assert property (@(posedge clk) disable iff (!rst_n)
        valid && ready && (token_kind == ots_pkg::KIND_EOF) |=>
        !valid || (token_kind == ots_pkg::KIND_EOF) || (lexeme_length != 2'd0))
        else $error("zero-length token after end of file");

endmodule

bind operator_token_scanner ots_checker u_ots_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .valid         (tokens.valid),
    .ready         (tokens.ready),
    .token_kind    (tokens.token_kind),
    .lexeme_length (tokens.lexeme_length),
    .bad_char      (tokens.bad_char),
    .run_last      (tokens.run_last)
);

/* dv/tb_operator_token_scanner.sv */
// Self-checking testbench for the operator token scanner: directed and random stimulus.
module tb_operator_token_scanner;
    import ots_pkg::*;

    // Cycles without any transfer before the run is declared hung.
    localparam int STALL_LIMIT = 500;
    // Cycles to wait after the last expected token for stray outputs.
    localparam int DRAIN_CYCLES = 8;
    // Random items that do something, and where the calm tail of the run starts.
    localparam int RANDOM_ITEMS = 270;
    localparam int CALM_FROM = 230;

    // One source item as the driver presents it.
    typedef struct {
        bit         has;
        logic [7:0] code;
        bit         fin;
        bit         calm;
    } src_item_t;

    // One token as the scanner should emit it.
    typedef struct {
        logic [4:0]             kind;
        logic [1:0]             len;
        logic [OFFSET_BITS-1:0] start;
        logic [LINE_BITS-1:0]   line;
        logic [7:0]             bad;
        logic                   last;
    } token_exp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ots_byte_if  byte_ch ();
    ots_token_if tok_ch ();

    operator_token_scanner i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .bytes  (byte_ch),
        .tokens (tok_ch)
    );

    // Clock generation.
    always #5 clk = ~clk;

    src_item_t  pending_items [$];
    token_exp_t due_tokens [$];
    token_exp_t item_toks [$];
    src_item_t  cur_item;

    // Scanner state mirrored by the predictor.
    op_t                    pend_op;
    logic [OFFSET_BITS-1:0] pend_off;
    bit                     in_cmt;
    logic [LINE_BITS-1:0]   line_cnt;
    logic [OFFSET_BITS-1:0] byte_off;

    bit byte_took = 1'b0;
    bit calm_now = 1'b0;
    int gap_left = 0;
    int hold_left = 0;
    int stall_cycles = 0;
    int errors = 0;

    // Source character of each single-character punctuator, indexed by its kind.
    function automatic logic [7:0] punct_char(input int idx);
        logic [7:0] c;
        case (idx)
            0: c = CH_LPAREN;
            1: c = CH_RPAREN;
            2: c = CH_LBRACE;
            3: c = CH_RBRACE;
            4: c = CH_COMMA;
            5: c = CH_DOT;
            6: c = CH_MINUS;
            7: c = CH_PLUS;
            8: c = CH_SEMICOLON;
            default: c = CH_STAR;
        endcase
        return c;
    endfunction

    // Operator kinds come in pairs, the two-byte form first; slash has no pair.
    function automatic logic [4:0] pair_kind(input op_t op, input bit with_eq);
        if (op == OP_SLASH)
            return KIND_SLASH;
        return KIND_BANG_EQ + 5'((int'(op) - 1) * 2) + (with_eq ? 5'd0 : 5'd1);
    endfunction

    function automatic void clear_state();
        pend_op  = OP_NONE;
        pend_off = '0;
        in_cmt   = 1'b0;
        line_cnt = LINE_BITS'(1);
        byte_off = '0;
    endfunction

    function automatic void bump_line();
        if (line_cnt != LINE_MAX)
            line_cnt = line_cnt + 1'b1;
    endfunction

    function automatic void emit_token(input logic [4:0] kind, input logic [1:0] len,
                                       input logic [OFFSET_BITS-1:0] start,
                                       input logic [7:0] bad);
        token_exp_t t;
        t.kind  = kind;
        t.len   = len;
        t.start = start;
        t.line  = line_cnt;
        t.bad   = bad;
        t.last  = 1'b0;
        item_toks = {item_toks, t};
    endfunction

    // Scan a byte with no operator waiting in the lookahead.
    function automatic void scan_byte(input logic [7:0] c);
        int i;
        for (i = 0; i < 10; i++)
        begin
            if (punct_char(i) == c)
            begin
                emit_token(5'(i), 2'd1, byte_off, 8'h00);
                return;
            end
        end
        case (c)
            CH_BANG:    pend_op = OP_BANG;
            CH_EQUAL:   pend_op = OP_EQUAL;
            CH_GREATER: pend_op = OP_GREATER;
            CH_LESS:    pend_op = OP_LESS;
            CH_SLASH:   pend_op = OP_SLASH;
            CH_SPACE, CH_TAB, CH_CR:
                return;
            CH_NEWLINE:
            begin
                bump_line();
                return;
            end
            default:
            begin
                emit_token(KIND_ERROR, 2'd1, byte_off, c);
                return;
            end
        endcase
        pend_off = byte_off;
    endfunction

    // Work out the tokens that one accepted source item causes.
    function automatic void scan_source_item(input bit has, input logic [7:0] c,
                                             input bit fin);
        item_toks.delete();
        if (has)
        begin
            if (in_cmt)
            begin
                if (c == CH_NEWLINE)
                begin
                    in_cmt = 1'b0;
                    bump_line();
                end
            end
            else if (pend_op != OP_NONE)
            begin
                if (c == CH_EQUAL && pend_op != OP_SLASH)
                begin
                    emit_token(pair_kind(pend_op, 1'b1), 2'd2, pend_off, 8'h00);
                    pend_op = OP_NONE;
                end
                else if (c == CH_SLASH && pend_op == OP_SLASH)
                begin
                    pend_op = OP_NONE;
                    in_cmt  = 1'b1;
                end
                else
                begin
                    emit_token(pair_kind(pend_op, 1'b0), 2'd1, pend_off, 8'h00);
                    pend_op = OP_NONE;
                    scan_byte(c);
                end
            end
            else
            begin
                scan_byte(c);
            end
            if (byte_off != OFFSET_MAX)
                byte_off = byte_off + 1'b1;
        end
        if (fin)
        begin
            if (pend_op != OP_NONE)
                emit_token(pair_kind(pend_op, 1'b0), 2'd1, pend_off, 8'h00);
            emit_token(KIND_EOF, 2'd0, byte_off, 8'h00);
            clear_state();
        end
        if (item_toks.size() > 0)
            item_toks[item_toks.size() - 1].last = 1'b1;
        foreach (item_toks[k])
            due_tokens = {due_tokens, item_toks[k]};
    endfunction

    task automatic push_item(input bit has, input logic [7:0] code, input bit fin,
                             input bit calm);
        src_item_t it;
        it.has  = has;
        it.code = code;
        it.fin  = fin;
        it.calm = calm;
        pending_items = {pending_items, it};
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            push_item(1'b1, s[i], 1'b0, 1'b0);
    endtask

    // Random byte biased toward characters the scanner knows.
    function automatic logic [7:0] next_char();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 35)
            return punct_char($urandom_range(0, 9));
        if (sel < 60)
        begin
            case ($urandom_range(0, 6))
                0: return CH_BANG;
                1: return CH_GREATER;
                2: return CH_LESS;
                3, 4: return CH_EQUAL;
                default: return CH_SLASH;
            endcase
        end
        if (sel < 75)
        begin
            case ($urandom_range(0, 3))
                0: return CH_SPACE;
                1: return CH_TAB;
                2: return CH_CR;
                default: return CH_NEWLINE;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Sample both channels at the rising edge: predict on byte transfers, check tokens.
    always @(posedge clk)
    begin
        token_exp_t want;
        byte_took = rst_n && byte_ch.valid && byte_ch.ready;
        if (byte_took)
            scan_source_item(byte_ch.has_char, byte_ch.char_code, byte_ch.is_final);
        if (rst_n && tok_ch.valid && tok_ch.ready)
        begin
            if (due_tokens.size() == 0)
            begin
                $error("token transfer with nothing expected: kind %0d", tok_ch.token_kind);
                errors++;
            end
            else
            begin
                want = due_tokens.pop_front();
                if (tok_ch.token_kind !== want.kind)
                begin
                    $error("token_kind: expected %0d, got %0d", want.kind, tok_ch.token_kind);
                    errors++;
                end
                if (tok_ch.lexeme_length !== want.len)
                begin
                    $error("lexeme_length: expected %0d, got %0d", want.len,
                           tok_ch.lexeme_length);
                    errors++;
                end
                if (tok_ch.start_offset !== want.start)
                begin
                    $error("start_offset: expected %0d, got %0d", want.start,
                           tok_ch.start_offset);
                    errors++;
                end
                if (tok_ch.line_number !== want.line)
                begin
                    $error("line_number: expected %0d, got %0d", want.line,
                           tok_ch.line_number);
                    errors++;
                end
                if (tok_ch.bad_char !== want.bad)
                begin
                    $error("bad_char: expected 0x%02h, got 0x%02h", want.bad, tok_ch.bad_char);
                    errors++;
                end
                if (tok_ch.run_last !== want.last)
                begin
                    $error("run_last: expected %0d, got %0d", want.last, tok_ch.run_last);
                    errors++;
                end
            end
        end
    end

    // Drive the byte channel and the token ready at the falling edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!byte_ch.valid || byte_took)
            begin
                if (gap_left > 0)
                begin
                    byte_ch.valid <= 1'b0;
                    gap_left--;
                end
                else if (pending_items.size() > 0)
                begin
                    cur_item = pending_items.pop_front();
                    byte_ch.valid     <= 1'b1;
                    byte_ch.has_char  <= cur_item.has;
                    byte_ch.char_code <= cur_item.code;
                    byte_ch.is_final  <= cur_item.fin;
                    calm_now = cur_item.calm;
                    if (!cur_item.calm && $urandom_range(0, 4) == 0)
                        gap_left = $urandom_range(1, 3);
                end
                else
                begin
                    byte_ch.valid <= 1'b0;
                end
            end
            if (hold_left > 0)
            begin
                tok_ch.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                tok_ch.ready <= 1'b1;
                if (!calm_now && $urandom_range(0, 4) == 0)
                    hold_left = $urandom_range(1, 3);
            end
        end
    end

    // Watchdog: too many cycles without a transfer on either channel.
    always @(posedge clk)
    begin
        if ((byte_ch.valid && byte_ch.ready) || (tok_ch.valid && tok_ch.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int  counted;
        bit  has;
        bit  fin;
        logic [7:0] code;

        byte_ch.valid     = 1'b0;
        byte_ch.has_char  = 1'b0;
        byte_ch.char_code = 8'h00;
        byte_ch.is_final  = 1'b0;
        tok_ch.ready      = 1'b0;
        clear_state();

        // Directed part: every punctuator, then every operator with an equals sign.
        push_text("(){},.-+;*");
        push_text("!=<=>===");
        // Operator followed by another operator, then a comment that swallows an unknown byte.
        push_text("!<>=//");
        push_item(1'b1, 8'hFF, 1'b0, 1'b0);
        push_item(1'b1, CH_NEWLINE, 1'b0, 1'b0);
        // Unknown bytes at both ends of the range, then the blanks.
        push_item(1'b1, 8'h00, 1'b0, 1'b0);
        push_item(1'b1, 8'hFF, 1'b0, 1'b0);
        push_item(1'b1, CH_SPACE, 1'b0, 1'b0);
        push_item(1'b1, CH_TAB, 1'b0, 1'b0);
        push_item(1'b1, CH_CR, 1'b0, 1'b0);
        // Empty item that changes nothing.
        push_item(1'b0, 8'hA5, 1'b0, 1'b0);
        // Pending operator, a punctuator and end of file from a single item.
        push_item(1'b1, CH_LESS, 1'b0, 1'b0);
        push_item(1'b1, CH_LPAREN, 1'b1, 1'b0);
        // End of file alone on a fresh source.
        push_item(1'b0, 8'h5A, 1'b1, 1'b0);
        // Lone slash, then a byte together with the final flag.
        push_item(1'b1, CH_SLASH, 1'b0, 1'b0);
        push_item(1'b1, CH_SPACE, 1'b0, 1'b0);
        push_item(1'b1, CH_EQUAL, 1'b1, 1'b0);

        // Random part; empty non-final items change nothing in the block and are not counted.
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            fin  = ($urandom_range(0, 24) == 0);
            has  = ($urandom_range(0, 19) != 0);
            code = has ? next_char() : 8'($urandom_range(0, 255));
            push_item(has, code, fin, counted >= CALM_FROM);
            if (has || fin)
                counted++;
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_items.size() != 0 || byte_ch.valid)
            @(posedge clk);
        while (due_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (due_tokens.size() != 0)
        begin
            $error("%0d expected tokens never arrived", due_tokens.size());
            errors++;
        end
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
